>>> rtl/i64div_pkg.sv
// Package for the 64-bit divider: widths, operation codes and the microcode table.
`default_nettype none

package i64div_pkg;

    // Operand width and derived widths.
    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int TDATA_W    = 2 * DATA_WIDTH;
    localparam int FUNC_W     = 2;
    localparam int UPC_W      = 3;

    typedef logic [UPC_W-1:0] upc_t;

    // Operation selector codes carried on the slave tuser.
    localparam logic [FUNC_W-1:0] FUNC_UNSIGNED = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SQUOT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SREM     = 2'd2;

    // Microprogram addresses.
    localparam upc_t UPC_IDLE = 3'd0;
    localparam upc_t UPC_ABS  = 3'd1;
    localparam upc_t UPC_STEP = 3'd2;
    localparam upc_t UPC_FIX  = 3'd3;
    localparam upc_t UPC_EMIT = 3'd4;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ABS,
        OP_STEP,
        OP_FIX,
        OP_EMIT
    } dp_op_t;

    // Jump condition tested by a control word.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_DIV_ZERO,
        COND_CNT_ZERO,
        COND_OUT_FREE
    } cond_t;

    // One control word: the datapath operation, whether it only fires when the
    // condition holds, the jump condition and target, and where to go otherwise.
    typedef struct packed {
        dp_op_t op;
        logic   gated;
        cond_t  cond;
        upc_t   target;
        logic   stay;
    } ctrl_word_t;

    // Read-only microprogram.
    function automatic ctrl_word_t ucode_rom(input upc_t upc);
        ctrl_word_t w;
        case (upc)
            UPC_IDLE: w = '{op: OP_LOAD, gated: 1'b1, cond: COND_IN_VALID,
                            target: UPC_ABS, stay: 1'b1};
            UPC_ABS:  w = '{op: OP_ABS, gated: 1'b0, cond: COND_DIV_ZERO,
                            target: UPC_EMIT, stay: 1'b0};
            UPC_STEP: w = '{op: OP_STEP, gated: 1'b0, cond: COND_CNT_ZERO,
                            target: UPC_FIX, stay: 1'b1};
            UPC_FIX:  w = '{op: OP_FIX, gated: 1'b0, cond: COND_ALWAYS,
                            target: UPC_EMIT, stay: 1'b0};
            UPC_EMIT: w = '{op: OP_EMIT, gated: 1'b1, cond: COND_OUT_FREE,
                            target: UPC_IDLE, stay: 1'b1};
            default:  w = '{op: OP_NOP, gated: 1'b0, cond: COND_ALWAYS,
                            target: UPC_IDLE, stay: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/int64_divider.sv
// Top level of the 64-bit shift-subtract divider with its microcoded sequencer.
`default_nettype none

// Integer divider, one word in and one word out.
// The slave channel takes dividend (tdata low half), divisor (tdata high half)
// and the operation on tuser: 0 unsigned quotient and remainder, 1 signed
// quotient, 2 signed remainder, 3 treated as 0.
// The master channel returns quotient (tdata low half), remainder (tdata high
// half) and the divide-by-zero flag on tuser; results are zero on that flag.
// A short microprogram steps a plain datapath: load, magnitude, one restoring
// subtract step per quotient bit, sign fix-up and hand-over.
// After acceptance the sequencer runs one magnitude step, the single one-bit
// restoring step once per quotient bit, one fix-up step and one hand-over
// step; a zero divisor skips the loop and the fix-up. One division runs at a
// time, so a new word is accepted once the previous result has moved into
// the output register.
// The output register holds a finished result while the receiver stalls;
// the sequencer waits at its hand-over step until that register is free.
// Reset returns the sequencer to idle and empties the output register.
module int64_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // dividend [63:0], divisor [127:64]
    input  wire logic [i64div_pkg::TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  wire logic [i64div_pkg::FUNC_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // quotient [63:0], remainder [127:64]
    output logic [i64div_pkg::TDATA_W-1:0]      m_tdata,
    // divide_by_zero [0]
    output logic [0:0]                         m_tuser
);

    localparam int DW = i64div_pkg::DATA_WIDTH;

    // Sequencer state.
    i64div_pkg::upc_t upc_reg, upc_next;
    i64div_pkg::ctrl_word_t cw;
    logic cond_true;
    logic op_en;

    // Datapath registers.
    logic [i64div_pkg::FUNC_W-1:0] func_reg;
    logic [DW-1:0] n_reg, n_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] r_reg, r_next;
    logic nneg_reg, nneg_next;
    logic dneg_reg, dneg_next;
    logic dz_reg, dz_next;
    logic [i64div_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Output register.
    logic m_valid_reg, m_valid_next;
    logic [i64div_pkg::TDATA_W-1:0] m_data_reg;
    logic m_dz_reg;

    logic signed_mode;
    logic out_free;
    logic [DW-1:0] shift_r;
    logic          ge;
    logic [DW-1:0] n_neg, d_neg, r_neg;

    assign signed_mode = (func_reg == i64div_pkg::FUNC_SQUOT) ||
                         (func_reg == i64div_pkg::FUNC_SREM);
    assign out_free    = !m_valid_reg || m_tready;

    // Control word fetch and condition test.
    always_comb begin
        cw = i64div_pkg::ucode_rom(upc_reg);
        case (cw.cond)
            i64div_pkg::COND_ALWAYS:   cond_true = 1'b1;
            i64div_pkg::COND_IN_VALID: cond_true = s_tvalid;
            i64div_pkg::COND_DIV_ZERO: cond_true = (d_reg == '0);
            i64div_pkg::COND_CNT_ZERO: cond_true = (cnt_reg == '0);
            i64div_pkg::COND_OUT_FREE: cond_true = out_free;
            default:                   cond_true = 1'b0;
        endcase
        op_en = !cw.gated || cond_true;
    end

    // Next microprogram address.
    always_comb begin
        if (cond_true) begin
            upc_next = cw.target;
        end else if (cw.stay) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + i64div_pkg::UPC_W'(1);
        end
    end

    // Outputs of the sequencer towards the ports.
    always_comb begin
        s_tready = (upc_reg == i64div_pkg::UPC_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
        m_tuser  = m_dz_reg;
    end

    // Shared arithmetic: negators and the restoring step.
    assign n_neg   = ~n_reg + DW'(1);
    assign d_neg   = ~d_reg + DW'(1);
    assign r_neg   = ~r_reg + DW'(1);
    assign shift_r = {r_reg[DW-2:0], n_reg[DW-1]};
    assign ge      = r_reg[DW-1] || (shift_r >= d_reg);

    // Datapath next values under the current control word.
    always_comb begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        nneg_next = nneg_reg;
        dneg_next = dneg_reg;
        dz_next   = dz_reg;
        cnt_next  = cnt_reg;
        case (cw.op)
            i64div_pkg::OP_LOAD: begin
                if (op_en) begin
                    n_next = s_tdata[DW-1:0];
                    d_next = s_tdata[2*DW-1:DW];
                end
            end
            i64div_pkg::OP_ABS: begin
                nneg_next = signed_mode && n_reg[DW-1];
                dneg_next = signed_mode && d_reg[DW-1];
                n_next    = (signed_mode && n_reg[DW-1]) ? n_neg : n_reg;
                d_next    = (signed_mode && d_reg[DW-1]) ? d_neg : d_reg;
                r_next    = '0;
                dz_next   = (d_reg == '0);
                cnt_next  = i64div_pkg::CNT_W'(DW - 1);
            end
            i64div_pkg::OP_STEP: begin
                r_next   = ge ? (shift_r - d_reg) : shift_r;
                n_next   = {n_reg[DW-2:0], ge};
                cnt_next = cnt_reg - i64div_pkg::CNT_W'(1);
            end
            i64div_pkg::OP_FIX: begin
                if (func_reg == i64div_pkg::FUNC_SQUOT) begin
                    n_next = (nneg_reg ^ dneg_reg) ? n_neg : n_reg;
                    r_next = '0;
                end else if (func_reg == i64div_pkg::FUNC_SREM) begin
                    n_next = '0;
                    r_next = nneg_reg ? r_neg : r_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register valid: set on hand-over, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cw.op == i64div_pkg::OP_EMIT && op_en) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= i64div_pkg::UPC_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cw.op == i64div_pkg::OP_LOAD && op_en) begin
            func_reg <= s_tuser;
        end
        n_reg    <= n_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
        dz_reg   <= dz_next;
        cnt_reg  <= cnt_next;
        if (cw.op == i64div_pkg::OP_EMIT && op_en) begin
            m_data_reg <= dz_reg ? '0 : {r_reg, n_reg};
            m_dz_reg   <= dz_reg;
        end
    end

`ifndef SYNTH
    // An accepted word always moves the sequencer on to the magnitude step.
    a_accept_to_abs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (upc_reg == i64div_pkg::UPC_ABS))
        else $error("accepted word did not start the magnitude step");

    // A new result only appears after the hand-over step.
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(upc_reg) == i64div_pkg::UPC_EMIT))
        else $error("result appeared outside the hand-over step");

    // The bit counter counts down once per restoring step.
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == i64div_pkg::UPC_STEP && cnt_reg != '0) |=>
        (upc_reg == i64div_pkg::UPC_STEP &&
         cnt_reg == $past(cnt_reg) - i64div_pkg::CNT_W'(1)))
        else $error("restoring loop lost its count");

    // The loop leaves for the sign fix-up once the last bit is done.
    a_loop_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == i64div_pkg::UPC_STEP && cnt_reg == '0) |=>
        (upc_reg == i64div_pkg::UPC_FIX))
        else $error("restoring loop did not exit to fix-up");

    // A divide-by-zero result carries zero quotient and remainder.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("divide by zero with nonzero data");
`endif

endmodule

`default_nettype wire
